// ===== rtl/core/srrw_pkg.sv =====
// package: types, constants and register indexes of the selective-repeat receive window
`timescale 1ns / 1ps
package srrw_pkg;

  localparam int MAX_WINDOW       = 32;
  localparam int MAX_FRAMES       = 1024;
  localparam int FRAME_DATA_BYTES = 1024;

  localparam int SEQ_W     = 10;
  localparam int LEN_W     = 11;
  localparam int BYTES_W   = 21;
  localparam int WIN_W     = 6;
  localparam int FRAMES_W  = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;

  localparam int MAP_W   = MAX_WINDOW;
  localparam int SHIFT_W = $clog2(MAX_WINDOW + 1);
  localparam int OFF_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int NE_W    = $clog2(MAX_FRAMES + MAX_WINDOW + 1);
  localparam int LIM_W   = NE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_BUFFER = CFG_IDX_W'(1);

  localparam logic [WIN_W-1:0]    WIN_WIDTH_RESET         = WIN_W'(4);
  localparam logic [FRAMES_W-1:0] FRAMES_PER_BUFFER_RESET = FRAMES_W'(256);

  typedef struct packed {
    logic [SEQ_W-1:0] seq_number;
    logic             frame_error;
    logic             end_flag;
    logic [LEN_W-1:0] data_bytes;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   ack_seq;
    logic               ack_negative;
    logic               store_enable;
    logic [SEQ_W-1:0]   store_slot;
    logic               buffer_complete;
    logic [BYTES_W-1:0] buffer_bytes;
    logic               transfer_complete;
  } out_item_t;

  // frames_per_buffer clamped into 1..MAX_FRAMES
  function automatic logic [CNT_W-1:0] eff_frames(input logic [FRAMES_W-1:0] f);
    logic [CNT_W-1:0] r;
    if (f == '0) r = CNT_W'(1);
    else if (32'(f) > MAX_FRAMES) r = CNT_W'(MAX_FRAMES);
    else r = CNT_W'(f);
    return r;
  endfunction

  // byte total of a full buffer
  function automatic logic [BYTES_W-1:0] full_bytes(input logic [CNT_W-1:0] n);
    return BYTES_W'(n * BYTES_W'(FRAME_DATA_BYTES));
  endfunction

endpackage

// ===== rtl/core/selective_repeat_receive_window_unit.sv =====
// selective-repeat receive window: acks, slot assignment, window slide and buffer completion
`timescale 1ns / 1ps
// One frame word in, one result word out per frame. A frame is registered on
// input and evaluated against the window state once the output register is
// free or being read (a priority find over the 32-bit received map slides the
// window), so the block takes one frame per cycle while the output is not
// stalled; the result is registered in the output register, and a full output
// register lets the next frame enter while a result waits. Configuration writes
// (index 0 window width, index 1 frames_per_buffer) are always ready and are
// meant to be issued only while no frame is in flight.
module selective_repeat_receive_window_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  srrw_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output srrw_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srrw_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import srrw_pkg::*;

  // configuration
  logic [WIN_W-1:0]    win_width;
  logic [FRAMES_W-1:0] frames_per_buffer;

  // window state
  logic [NE_W-1:0]    next_expected;
  logic [MAP_W-1:0]   received_map;
  logic [CNT_W-1:0]   expected_count;
  logic [BYTES_W-1:0] final_bytes;
  logic               end_seen;

  // input stage
  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;

  // step logic
  logic [WIN_W-1:0]   w_eff;
  logic [CNT_W-1:0]   f_eff;
  logic [MAP_W-1:0]   win_mask;
  logic [MAP_W-1:0]   map_m;
  logic [SHIFT_W-1:0] run_shift;
  logic [LIM_W-1:0]   win_limit;
  logic [NE_W-1:0]    seq_ext;
  logic [OFF_W-1:0]   offset;
  logic [LEN_W-1:0]   len_sat;
  logic               accept_frame;
  logic               store;
  logic               done;
  logic [NE_W-1:0]    next_expected_next;
  logic [MAP_W-1:0]   received_map_next;
  logic [CNT_W-1:0]   expected_count_next;
  logic [BYTES_W-1:0] final_bytes_next;
  logic               end_seen_next;
  out_item_t          result;
  logic [CNT_W-1:0]   cfg_frames_eff;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (win_width == '0) w_eff = WIN_W'(1);
    else if (32'(win_width) > MAX_WINDOW) w_eff = WIN_W'(MAX_WINDOW);
    else w_eff = win_width;

    f_eff = eff_frames(frames_per_buffer);

    if (32'(w_eff) >= MAP_W) win_mask = '1;
    else win_mask = (MAP_W'(1) << w_eff) - MAP_W'(1);
    map_m = received_map & win_mask;

    // first missing frame above the head; bits beyond the window are clear
    run_shift = SHIFT_W'(MAP_W);
    for (int i = MAP_W - 1; i >= 1; i--) begin
      if (!map_m[i]) run_shift = SHIFT_W'(i);
    end

    seq_ext   = NE_W'(s1_item.seq_number);
    win_limit = LIM_W'(next_expected) + LIM_W'(w_eff);
    offset    = OFF_W'(seq_ext - next_expected);
    len_sat   = (32'(s1_item.data_bytes) > FRAME_DATA_BYTES) ?
                LEN_W'(FRAME_DATA_BYTES) : s1_item.data_bytes;

    accept_frame = !s1_item.frame_error && (CNT_W'(s1_item.seq_number) < f_eff) &&
                   (LIM_W'(seq_ext) < win_limit);

    store               = 1'b0;
    next_expected_next  = next_expected;
    received_map_next   = map_m;
    expected_count_next = expected_count;
    final_bytes_next    = final_bytes;
    end_seen_next       = end_seen;

    if (accept_frame) begin
      if (seq_ext == next_expected) begin
        store              = 1'b1;
        received_map_next  = map_m >> run_shift;
        next_expected_next = next_expected + NE_W'(run_shift);
      end else if (seq_ext > next_expected) begin
        if (!map_m[offset]) begin
          store                     = 1'b1;
          received_map_next[offset] = 1'b1;
        end
      end
      if (s1_item.end_flag) begin
        final_bytes_next = BYTES_W'(s1_item.seq_number * BYTES_W'(FRAME_DATA_BYTES)) +
                           BYTES_W'(len_sat);
        expected_count_next = CNT_W'(s1_item.seq_number) + CNT_W'(1);
        end_seen_next       = 1'b1;
      end
    end

    done = (LIM_W'(next_expected_next) >= LIM_W'(expected_count_next));

    result.ack_seq           = s1_item.seq_number;
    result.ack_negative      = s1_item.frame_error;
    result.store_enable      = store;
    result.store_slot        = store ? s1_item.seq_number : '0;
    result.buffer_complete   = done;
    result.buffer_bytes      = done ? final_bytes_next : '0;
    result.transfer_complete = done && end_seen_next;

    cfg_frames_eff = eff_frames(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_width         <= WIN_WIDTH_RESET;
      frames_per_buffer <= FRAMES_PER_BUFFER_RESET;
      next_expected     <= '0;
      received_map      <= '0;
      expected_count    <= eff_frames(FRAMES_PER_BUFFER_RESET);
      final_bytes       <= full_bytes(eff_frames(FRAMES_PER_BUFFER_RESET));
      end_seen          <= 1'b0;
    end else if (advance) begin
      if (done) begin
        next_expected  <= '0;
        received_map   <= '0;
        expected_count <= f_eff;
        final_bytes    <= full_bytes(f_eff);
        end_seen       <= 1'b0;
      end else begin
        next_expected  <= next_expected_next;
        received_map   <= received_map_next;
        expected_count <= expected_count_next;
        final_bytes    <= final_bytes_next;
        end_seen       <= end_seen_next;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIN_WIDTH: begin
          win_width <= WIN_W'(cfg_data);
        end
        REG_FRAMES_PER_BUFFER: begin
          frames_per_buffer <= cfg_data;
          // buffer size follows the register until an end frame fixes it
          if (!end_seen) begin
            expected_count <= cfg_frames_eff;
            final_bytes    <= full_bytes(cfg_frames_eff);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // completion returns the window to its start
  a_restart: assert property (@(posedge clk) disable iff (rst)
    advance && done |=> next_expected == '0 && received_map == '0 && !end_seen)
    else $error("window not restarted after buffer completion");

  // the head frame is never marked as already held
  a_head_clear: assert property (@(posedge clk) disable iff (rst)
    !received_map[0])
    else $error("received map marks the expected frame");

  // a processed frame always lands in the output register
  a_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && out_data.ack_seq == $past(s1_item.seq_number))
    else $error("frame result lost");

  // a final buffer is always a completed buffer
  a_final: assert property (@(posedge clk) disable iff (rst)
    advance && result.transfer_complete |=> out_data.buffer_complete && $past(end_seen_next))
    else $error("transfer complete without buffer completion");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench: directed and random frames through the receive window, acks checked against a tracker
module tb;
  import srrw_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASES       = 10;
  localparam int PHASE_FRAMES = 130;

  // follows the window state and predicts the ack word of every accepted frame
  class rx_window_tracker;
    logic [WIN_W-1:0]    win_reg;
    logic [FRAMES_W-1:0] frames_reg;
    int unsigned         next_exp;
    logic [63:0]         rx_map;
    int unsigned         exp_count;
    int unsigned         fin_bytes;
    bit                  end_seen;
    out_item_t           pending_acks[$];
    int unsigned         ack_mismatches;

    function new();
      win_reg        = WIN_WIDTH_RESET;
      frames_reg     = FRAMES_PER_BUFFER_RESET;
      ack_mismatches = 0;
      restart();
    endfunction

    function int unsigned eff_win();
      int unsigned w;
      w = win_reg;
      if (w < 1) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      return w;
    endfunction

    function int unsigned eff_frm();
      int unsigned f;
      f = frames_reg;
      if (f < 1) f = 1;
      if (f > MAX_FRAMES) f = MAX_FRAMES;
      return f;
    endfunction

    function void restart();
      next_exp  = 0;
      rx_map    = '0;
      exp_count = eff_frm();
      fin_bytes = eff_frm() * FRAME_DATA_BYTES;
      end_seen  = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == REG_WIN_WIDTH) begin
        win_reg = data[WIN_W-1:0];
      end else if (idx == REG_FRAMES_PER_BUFFER) begin
        frames_reg = data[FRAMES_W-1:0];
        // buffer size follows the register only until an end frame fixed it
        if (!end_seen) begin
          exp_count = eff_frm();
          fin_bytes = eff_frm() * FRAME_DATA_BYTES;
        end
      end
    endfunction

    function void note_frame(in_item_t f);
      int unsigned seq, len, w, shift, off;
      bit          store;
      out_item_t   e;
      seq   = f.seq_number;
      len   = f.data_bytes;
      if (len > FRAME_DATA_BYTES) len = FRAME_DATA_BYTES;
      w     = eff_win();
      store = 1'b0;
      // bits left over from a wider window are dropped
      rx_map &= (64'd1 << w) - 64'd1;
      if (!f.frame_error && seq < eff_frm() && seq < next_exp + w) begin
        if (seq == next_exp) begin
          store = 1'b1;
          shift = 1;
          while (shift < w && rx_map[shift]) shift++;
          rx_map   = rx_map >> shift;
          next_exp = next_exp + shift;
        end else if (seq > next_exp) begin
          off = seq - next_exp;
          if (!rx_map[off]) begin
            store       = 1'b1;
            rx_map[off] = 1'b1;
          end
        end
        if (f.end_flag) begin
          fin_bytes = seq * FRAME_DATA_BYTES + len;
          exp_count = seq + 1;
          end_seen  = 1'b1;
        end
      end
      e.ack_seq           = f.seq_number;
      e.ack_negative      = f.frame_error;
      e.store_enable      = store;
      e.store_slot        = store ? f.seq_number : '0;
      e.buffer_complete   = 1'b0;
      e.buffer_bytes      = '0;
      e.transfer_complete = 1'b0;
      if (next_exp >= exp_count) begin
        e.buffer_complete   = 1'b1;
        e.buffer_bytes      = BYTES_W'(fin_bytes);
        e.transfer_complete = end_seen;
        restart();
      end
      pending_acks.push_back(e);
    endfunction

    function string show(out_item_t a);
      return $sformatf("seq=%0d nak=%0b st=%0b slot=%0d done=%0b bytes=%0d last=%0b",
                       a.ack_seq, a.ack_negative, a.store_enable, a.store_slot,
                       a.buffer_complete, a.buffer_bytes, a.transfer_complete);
    endfunction

    function void check_ack(out_item_t got);
      out_item_t e;
      if (pending_acks.size() == 0) begin
        ack_mismatches++;
        if (ack_mismatches <= 10) $display("unexpected ack word: %s", show(got));
      end else begin
        e = pending_acks.pop_front();
        if (got.ack_seq !== e.ack_seq || got.ack_negative !== e.ack_negative ||
            got.store_enable !== e.store_enable || got.store_slot !== e.store_slot ||
            got.buffer_complete !== e.buffer_complete ||
            got.buffer_bytes !== e.buffer_bytes ||
            got.transfer_complete !== e.transfer_complete) begin
          ack_mismatches++;
          if (ack_mismatches <= 10)
            $display("ack mismatch: expected %s got %s", show(e), show(got));
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  rx_window_tracker trk;
  bit               no_idle = 1'b0;
  int               hold_cnt = 0;
  int               idle_cycles = 0;

  selective_repeat_receive_window_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (no_idle) begin
      out_ready = 1'b1;
    end else if (out_ready) begin
      out_ready = 1'b0;
      hold_cnt  = pick_gap();
    end else begin
      out_ready = 1'b1;
      hold_cnt  = $urandom_range(0, 12);
    end
  end

  // accepted words feed the tracker; the watchdog runs on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) trk.note_frame(in_data);
      if (cfg_valid && cfg_ready) trk.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) trk.check_ack(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic in_item_t frame(int seq, bit err, bit eot, int len);
    in_item_t f;
    f.seq_number  = SEQ_W'(seq);
    f.frame_error = err;
    f.end_flag    = eot;
    f.data_bytes  = LEN_W'(len);
    return f;
  endfunction

  // biased toward the window so buffers actually complete
  function automatic in_item_t rand_frame();
    in_item_t    f;
    int unsigned w, fr, ne, seq;
    int          r;
    w  = trk.eff_win();
    fr = trk.eff_frm();
    ne = trk.next_exp;
    r  = $urandom_range(0, 99);
    if (r < 20) seq = ne;
    else if (r < 65) seq = ne + $urandom_range(0, w - 1);
    else if (r < 75) seq = (ne > 0) ? $urandom_range(0, ne - 1) : 0;
    else if (r < 85) seq = $urandom_range(0, 1023);
    else seq = ne + $urandom_range(w, w + 3);
    f.seq_number  = SEQ_W'(seq);
    f.frame_error = ($urandom_range(0, 9) == 0);
    f.end_flag    = ($urandom_range(0, 24) == 0) || (seq == fr - 1 && $urandom_range(0, 1) == 1);
    r = $urandom_range(0, 9);
    if (r == 0) f.data_bytes = '0;
    else if (r == 1) f.data_bytes = LEN_W'(FRAME_DATA_BYTES);
    else if (r == 2) f.data_bytes = LEN_W'($urandom_range(FRAME_DATA_BYTES + 1, 2047));
    else f.data_bytes = LEN_W'($urandom_range(0, FRAME_DATA_BYTES));
    return f;
  endfunction

  task automatic send_frame(in_item_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = f;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_index = idx;
    cfg_data  = CFG_DAT_W'(data);
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (trk.pending_acks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int p, i, r, wv, fv;
    trk = new();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // reset settings: window 4, 256 frames
    send_frame(frame(0, 0, 0, 1024));
    send_frame(frame(2, 0, 0, 0));
    send_frame(frame(2, 0, 0, 5));       // duplicate
    send_frame(frame(0, 0, 0, 7));       // below the window
    send_frame(frame(1, 1, 0, 3));       // nak
    send_frame(frame(1, 0, 0, 2047));    // slides past frame 2
    send_frame(frame(1023, 0, 0, 100));  // beyond the buffer
    send_frame(frame(7, 0, 0, 10));      // just past the window edge
    send_frame(frame(6, 0, 1, 1025));    // end frame, oversized payload
    send_frame(frame(3, 0, 0, 1));
    send_frame(frame(4, 0, 0, 1));
    send_frame(frame(5, 0, 0, 1));

    // both registers below range
    wait_drain();
    write_cfg(REG_WIN_WIDTH, 0);
    write_cfg(REG_FRAMES_PER_BUFFER, 0);
    send_frame(frame(0, 0, 0, 1));
    send_frame(frame(5, 0, 0, 1));

    // both registers above range
    wait_drain();
    write_cfg(REG_WIN_WIDTH, 63);
    write_cfg(REG_FRAMES_PER_BUFFER, 2047);
    send_frame(frame(31, 0, 0, 1));
    send_frame(frame(32, 0, 0, 1));
    send_frame(frame(0, 0, 0, 1));

    // shrink the window, then a size write after the end frame
    wait_drain();
    write_cfg(REG_WIN_WIDTH, 2);
    send_frame(frame(2, 0, 1, 1025));
    wait_drain();
    write_cfg(REG_FRAMES_PER_BUFFER, 5);
    send_frame(frame(1, 0, 0, 0));
    send_frame(frame(0, 1, 1, 0));       // end flag on a bad frame
    send_frame(frame(0, 0, 0, 0));
    send_frame(frame(0, 0, 1, 500));     // end flag on a frame below the window

    for (p = 0; p < PHASES; p++) begin
      wait_drain();
      no_idle = (p % 4 == 1);
      r = $urandom_range(0, 99);
      if (r < 15) wv = 0;
      else if (r < 25) wv = 63;
      else if (r < 35) wv = 32;
      else if (r < 45) wv = 1;
      else wv = $urandom_range(2, 16);
      wv = wv | ($urandom_range(0, 31) << WIN_W);
      r = $urandom_range(0, 99);
      if (r < 10) fv = 0;
      else if (r < 20) fv = 2047;
      else if (r < 25) fv = 1024;
      else if (r < 35) fv = 1;
      else if (r < 80) fv = $urandom_range(2, 40);
      else fv = $urandom_range(41, 300);
      if ($urandom_range(0, 1) == 1) begin
        write_cfg(REG_WIN_WIDTH, wv);
        write_cfg(REG_FRAMES_PER_BUFFER, fv);
      end else begin
        write_cfg(REG_FRAMES_PER_BUFFER, fv);
        write_cfg(REG_WIN_WIDTH, wv);
      end
      for (i = 0; i < PHASE_FRAMES; i++) begin
        send_frame(rand_frame());
        if ($urandom_range(0, 199) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (10) @(negedge clk);
    if (trk.ack_mismatches == 0 && trk.pending_acks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/srrw_pkg.sv
rtl/core/selective_repeat_receive_window_unit.sv
tb/sv/tb.sv
